@@ hdl/rmq_pkg.sv @@
// rmq_pkg: widths, stage counts, branch codes and the sideband struct shared by
// the rotation matrix to quaternion pipeline. No dependencies.
package rmq_pkg;

   localparam int ELEM_W    = 16;               // matrix element width
   localparam int FRAC_BITS = 14;               // fraction bits of Q1.14
   localparam int CALC_W    = ELEM_W + 3;       // exact trace / radicand width
   localparam int MAG_W     = ELEM_W + 1;       // magnitude of a raw vector entry
   localparam int NORM_W    = 30;               // bit length after normalizing
   localparam int SHIFT_W   = 5;                // normalizing shift amount
   localparam int LEN_W     = 5;                // bit length of the largest entry
   localparam int SQ_W      = 2 * NORM_W;       // one square
   localparam int SUM_W     = SQ_W + 2;         // sum of four squares
   localparam int SQ_STEPS  = SUM_W / 2 + 1;    // root digits, one per stage
   localparam int SQ_RES_W  = SUM_W + 1;        // working root register
   localparam int ROOT_W    = SUM_W / 2;        // final root width
   localparam int QUO_W     = FRAC_BITS + 1;    // quotient bits, one per stage
   localparam int NUM_W     = NORM_W + FRAC_BITS;
   localparam int OUT_W     = 16;
   localparam int LANES     = 4;
   localparam int MAG_DLY   = 2 + SQ_STEPS;     // squares, sum, root
   localparam int SIDE_DLY  = MAG_DLY + QUO_W + 1;

   localparam logic signed [CALC_W-1:0] ONE_CALC = CALC_W'(1) <<< FRAC_BITS;
   localparam logic signed [OUT_W-1:0]  ONE_OUT  = OUT_W'(1) <<< FRAC_BITS;

   // branch codes
   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   // per-beat control that rides alongside the data
   typedef struct packed {
      logic             valid;
      logic [1:0]       branch;
      logic             degenerate;
      logic [LANES-1:0] neg;
   } rmq_side_type;

endpackage

@@ hdl/rotation_matrix_to_quaternion_top.sv @@
// rotation_matrix_to_quaternion_top: 3x3 rotation matrix to unit quaternion.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div_lane.
//
// Converts one row-major Q1.14 rotation matrix per beat into a unit
// quaternion (x, y, z, w) in Q1.14 with the branch of Shepperd's method that
// was taken and a degenerate flag (identity returned when the radicand is not
// positive). The block is a fully pipelined datapath: it accepts a new matrix
// every cycle while no result is stalled, and each result passes through the
// 3 front stages, squares, sum, 32 square-root digit stages, 15 divider
// stages and a rounding stage. Four divider lanes run side by side, one per
// component. A stall on a valid result beat freezes the whole pipeline, the
// result held on the outputs included, and stalls the request channel in the
// same cycle.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_m00,
   input  logic signed [ELEM_W-1:0] req_m01,
   input  logic signed [ELEM_W-1:0] req_m02,
   input  logic signed [ELEM_W-1:0] req_m10,
   input  logic signed [ELEM_W-1:0] req_m11,
   input  logic signed [ELEM_W-1:0] req_m12,
   input  logic signed [ELEM_W-1:0] req_m20,
   input  logic signed [ELEM_W-1:0] req_m21,
   input  logic signed [ELEM_W-1:0] req_m22,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_quat_x,
   output logic signed [OUT_W-1:0]  rsp_quat_y,
   output logic signed [OUT_W-1:0]  rsp_quat_z,
   output logic signed [OUT_W-1:0]  rsp_quat_w,
   output logic [1:0]               rsp_branch_taken,
   output logic                     rsp_degenerate
);

   logic                     en;
   logic signed [ELEM_W-1:0] elem [9];
   rmq_side_type             front_side;
   logic [NORM_W-1:0]        front_mag [LANES];
   rmq_side_type             side_ff [SIDE_DLY];
   logic [NORM_W-1:0]        mag_dly_ff [MAG_DLY][LANES];
   logic [SQ_W-1:0]          sq_ff [LANES];
   logic [SUM_W-1:0]         sum_ff;
   logic [ROOT_W-1:0]        root;
   logic signed [OUT_W-1:0]  comp [LANES];
   rmq_side_type             out_side;

   // pipeline advances unless the held result is stalled
   assign out_side  = side_ff[SIDE_DLY-1];
   assign en        = !(out_side.valid && rsp_stall);
   assign req_stall = !en;

   assign elem[0] = req_m00;
   assign elem[1] = req_m01;
   assign elem[2] = req_m02;
   assign elem[3] = req_m10;
   assign elem[4] = req_m11;
   assign elem[5] = req_m12;
   assign elem[6] = req_m20;
   assign elem[7] = req_m21;
   assign elem[8] = req_m22;

   rmq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .elem     (elem),
      .side     (front_side),
      .mag      (front_mag)
   );

   // sideband delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SIDE_DLY; j++) begin
            side_ff[j] <= '0;
         end
      end else if (en) begin
         side_ff[0] <= front_side;
         for (int j = 1; j < SIDE_DLY; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // magnitudes wait for the root; squares and their sum
   always_ff @(posedge clock) begin
      if (en) begin
         mag_dly_ff[0] <= front_mag;
         for (int j = 1; j < MAG_DLY; j++) begin
            mag_dly_ff[j] <= mag_dly_ff[j-1];
         end
         for (int i = 0; i < LANES; i++) begin
            sq_ff[i] <= SQ_W'(front_mag[i]) * SQ_W'(front_mag[i]);
         end
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2])
                 + SUM_W'(sq_ff[3]);
      end
   end

   rmq_sqrt u_sqrt (
      .clock  (clock),
      .en     (en),
      .rad_in (sum_ff),
      .root   (root)
   );

   // one divider lane per component
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      rmq_div_lane u_lane (
         .clock (clock),
         .en    (en),
         .mag   (mag_dly_ff[MAG_DLY-1][i]),
         .neg   (side_ff[MAG_DLY-1].neg[i]),
         .root  (root),
         .comp  (comp[i])
      );
   end

   // merge lanes, identity on a degenerate beat
   assign rsp_valid        = out_side.valid;
   assign rsp_branch_taken = out_side.branch;
   assign rsp_degenerate   = out_side.degenerate;
   assign rsp_quat_x = out_side.degenerate ? '0 : comp[0];
   assign rsp_quat_y = out_side.degenerate ? '0 : comp[1];
   assign rsp_quat_z = out_side.degenerate ? '0 : comp[2];
   assign rsp_quat_w = out_side.degenerate ? ONE_OUT : comp[3];

endmodule

@@ hdl/rmq_front.sv @@
// rmq_front: branch choice, raw quaternion vector, magnitudes and the common
// normalizing shift (three register stages). Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [ELEM_W-1:0] elem [9],
   output rmq_side_type             side,
   output logic [NORM_W-1:0]        mag [LANES]
);

   logic signed [CALC_W-1:0] e [9];
   logic signed [CALC_W-1:0] trace, rad;
   logic signed [CALC_W-1:0] v [LANES];
   logic signed [CALC_W-1:0] av;
   logic [1:0]               branch_in;
   rmq_side_type             side1_in, side1_ff, side2_ff, side3_ff;
   logic [MAG_W-1:0]         mag1_in [LANES];
   logic [MAG_W-1:0]         mag1_ff [LANES];
   logic [MAG_W-1:0]         mag2_ff [LANES];
   logic [NORM_W-1:0]        mag3_ff [LANES];
   logic [MAG_W-1:0]         any_bits;
   logic [LEN_W-1:0]         len;
   logic [SHIFT_W-1:0]       shift_in, shift_ff;

   // branch select and raw vector
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = CALC_W'(elem[i]);
      end
      trace = e[0] + e[4] + e[8];
      if (trace > 0) begin
         branch_in = BR_TRACE;
         rad  = trace + ONE_CALC;
         v[0] = e[7] - e[5];
         v[1] = e[2] - e[6];
         v[2] = e[3] - e[1];
         v[3] = rad;
      end else if (e[0] > e[4] && e[0] > e[8]) begin
         branch_in = BR_X;
         rad  = ONE_CALC + e[0] - e[4] - e[8];
         v[0] = rad;
         v[1] = e[1] + e[3];
         v[2] = e[2] + e[6];
         v[3] = e[7] - e[5];
      end else if (e[4] > e[8]) begin
         branch_in = BR_Y;
         rad  = ONE_CALC + e[4] - e[0] - e[8];
         v[0] = e[1] + e[3];
         v[1] = rad;
         v[2] = e[5] + e[7];
         v[3] = e[2] - e[6];
      end else begin
         branch_in = BR_Z;
         rad  = ONE_CALC + e[8] - e[0] - e[4];
         v[0] = e[2] + e[6];
         v[1] = e[5] + e[7];
         v[2] = rad;
         v[3] = e[3] - e[1];
      end
      side1_in.valid      = in_valid;
      side1_in.branch     = branch_in;
      side1_in.degenerate = (rad <= 0);
      av = '0;
      for (int i = 0; i < LANES; i++) begin
         side1_in.neg[i] = v[i][CALC_W-1];
         av = v[i][CALC_W-1] ? -v[i] : v[i];
         mag1_in[i] = av[MAG_W-1:0];
      end
   end

   // bit length of the largest magnitude
   always_comb begin
      any_bits = '0;
      for (int i = 0; i < LANES; i++) begin
         any_bits = any_bits | mag1_ff[i];
      end
      len = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (any_bits[b]) begin
            len = LEN_W'(b + 1);
         end
      end
      shift_in = SHIFT_W'(NORM_W) - SHIFT_W'(len);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
         side2_ff <= '0;
         side3_ff <= '0;
      end else if (en) begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en) begin
         shift_ff <= shift_in;
         for (int i = 0; i < LANES; i++) begin
            mag1_ff[i] <= mag1_in[i];
            mag2_ff[i] <= mag1_ff[i];
            mag3_ff[i] <= NORM_W'(mag2_ff[i]) << shift_ff;
         end
      end
   end

   assign side = side3_ff;
   assign mag  = mag3_ff;

endmodule

@@ hdl/rmq_sqrt.sv @@
// rmq_sqrt: pipelined integer square root, one root digit per stage.
// Depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [SUM_W-1:0]  rad_in,
   output logic [ROOT_W-1:0] root
);

   logic [SUM_W-1:0]    x_ff   [SQ_STEPS];
   logic [SQ_RES_W-1:0] res_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [SQ_RES_W-1:0] STEP_BIT = SQ_RES_W'(1) << (SUM_W - 2 * k);
      logic [SQ_RES_W-1:0] x_cur, res_cur, trial;
      logic [SUM_W-1:0]    x_in;
      logic [SQ_RES_W-1:0] res_in;

      if (k == 0) begin : g_first
         assign x_cur   = SQ_RES_W'(rad_in);
         assign res_cur = '0;
      end else begin : g_next
         assign x_cur   = SQ_RES_W'(x_ff[k-1]);
         assign res_cur = res_ff[k-1];
      end

      // try the next digit
      always_comb begin
         trial = res_cur + STEP_BIT;
         if (x_cur >= trial) begin
            x_in   = SUM_W'(x_cur - trial);
            res_in = (res_cur >> 1) + STEP_BIT;
         end else begin
            x_in   = x_cur[SUM_W-1:0];
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]   <= x_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[SQ_STEPS-1][ROOT_W-1:0];

endmodule

@@ hdl/rmq_div_lane.sv @@
// rmq_div_lane: one quaternion component, magnitude scaled by ONE over the
// root, restoring division one quotient bit per stage, round half up, sign.
// Depends on rmq_pkg.
module rmq_div_lane import rmq_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic [NORM_W-1:0]       mag,
   input  logic                    neg,
   input  logic [ROOT_W-1:0]       root,
   output logic signed [OUT_W-1:0] comp
);

   logic [NUM_W-1:0]  rem_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];
   logic [ROOT_W-1:0] dvs_ff [QUO_W];
   logic              neg_ff [QUO_W];
   logic [QUO_W-1:0]  rnd_in;
   logic signed [OUT_W-1:0] comp_in, comp_ff;

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      localparam int BIT_POS = QUO_W - 1 - j;
      logic [NUM_W-1:0]  rem_cur, rem_in;
      logic [QUO_W-1:0]  quo_cur, quo_in;
      logic [ROOT_W-1:0] dvs_cur;
      logic              neg_cur;
      logic [NUM_W:0]    sub;

      if (j == 0) begin : g_first
         assign rem_cur = {mag, FRAC_BITS'(0)};
         assign quo_cur = '0;
         assign dvs_cur = root;
         assign neg_cur = neg;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign quo_cur = quo_ff[j-1];
         assign dvs_cur = dvs_ff[j-1];
         assign neg_cur = neg_ff[j-1];
      end

      // compare against the shifted divisor
      always_comb begin
         sub    = (NUM_W + 1)'(dvs_cur) << BIT_POS;
         rem_in = rem_cur;
         quo_in = quo_cur;
         if ((NUM_W + 1)'(rem_cur) >= sub) begin
            rem_in          = NUM_W'((NUM_W + 1)'(rem_cur) - sub);
            quo_in[BIT_POS] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            dvs_ff[j] <= dvs_cur;
            neg_ff[j] <= neg_cur;
         end
      end
   end

   // round half up and apply the sign
   always_comb begin
      rnd_in = quo_ff[QUO_W-1];
      if ({rem_ff[QUO_W-1], 1'b0} >= (NUM_W + 1)'(dvs_ff[QUO_W-1])) begin
         rnd_in = rnd_in + QUO_W'(1);
      end
      comp_in = neg_ff[QUO_W-1] ? -OUT_W'(rnd_in) : OUT_W'(rnd_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         comp_ff <= comp_in;
      end
   end

   assign comp = comp_ff;

endmodule

@@ hdl/rmq_checker.sv @@
// rmq_checker: port-level assertions for rotation_matrix_to_quaternion_top,
// bound to the top level. Depends on rmq_pkg.
module rmq_checker import rmq_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [OUT_W-1:0] rsp_quat_x,
   input logic signed [OUT_W-1:0] rsp_quat_y,
   input logic signed [OUT_W-1:0] rsp_quat_z,
   input logic signed [OUT_W-1:0] rsp_quat_w,
   input logic [1:0]              rsp_branch_taken,
   input logic                    rsp_degenerate
);

   // no result beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_x)
         && $stable(rsp_quat_y) && $stable(rsp_quat_z) && $stable(rsp_quat_w)
         && $stable(rsp_branch_taken) && $stable(rsp_degenerate))
      else $error("stalled result beat changed");

   // degenerate beat carries the identity
   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_quat_x == 0 && rsp_quat_y == 0
         && rsp_quat_z == 0 && rsp_quat_w == ONE_OUT)
      else $error("degenerate beat is not the identity");

   // unit quaternion components stay within one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_x <= ONE_OUT && rsp_quat_x >= -ONE_OUT
         && rsp_quat_y <= ONE_OUT && rsp_quat_y >= -ONE_OUT
         && rsp_quat_z <= ONE_OUT && rsp_quat_z >= -ONE_OUT
         && rsp_quat_w <= ONE_OUT && rsp_quat_w >= -ONE_OUT)
      else $error("quaternion component out of range");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);
